>>> hdl/hma_pkg.sv
// ----------------------------------------------------------------------------
// hma_pkg
// Shared types and constants for the hull moving average block.
// ----------------------------------------------------------------------------
`default_nettype none
package hma_pkg;

   localparam int MAX_PERIOD_DEF = 256;
   localparam int DIFF_DEPTH_DEF = 16;
   localparam int PERIOD_W       = 9;
   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 9'd20;
   localparam int PRICE_W        = 32;
   localparam int DIFF_W         = 35;
   localparam int HMA_W          = 34;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROOT,
      ST_WALK,
      ST_DIVIDE,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      PH_FULL,
      PH_HALF,
      PH_DIFF
   } phase_type;

   typedef struct packed {
      logic start;
      logic done;
   } div_ctl_type;

endpackage
`default_nettype wire

>>> hdl/hma_ram.sv
// ----------------------------------------------------------------------------
// hma_ram
// Generic simple dual port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none
module hma_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> hdl/hma_div.sv
// ----------------------------------------------------------------------------
// hma_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module hma_div #(
   parameter int NUM_W = 52,
   parameter int DEN_W = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [NUM_W-1:0]  dividend,
   input  wire logic [DEN_W-1:0]  divisor,
   output hma_pkg::div_ctl_type   status,
   output logic      [NUM_W-1:0]  quotient
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   trial;
   logic             fits;

   assign trial = {rem_ff, quo_ff[NUM_W-1]};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[NUM_W-2:0], fits};
         rem_in = fits ? DEN_W'(trial - {1'b0, den_ff}) : DEN_W'(trial);
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign status.start = start;
   assign status.done  = done_ff;
   assign quotient     = quo_ff;

endmodule
`default_nettype wire

>>> hdl/hull_moving_average.sv
// ----------------------------------------------------------------------------
// hull_moving_average
// Streaming hull moving average over unsigned Q16.16 close prices.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one close price per request (req_valid / req_stall).
//   rsp channel: one signed Q17.16 hull value per request.
//   csr channel: writes the period register (reset value 20); write only
//   while the block is idle.
// Steps per request, with n the clamped period:
//   a root search for s = floor(sqrt(n)), three window walks over L samples
//   (L = min(n, samples seen), min(n/2, samples seen) and the diff window),
//   three divisions of the ACC_W-bit accumulator (ACC_W = 52 at the default
//   parameters) in the shared divider, and a load of the output register.
//   req_stall is high for the whole computation.
// The result sits in an output register; while rsp_stall is high the
// block may already accept and compute the next request, and holds the
// next result back until the register is free.
// Reset is synchronous and clears control state; ring contents are only
// read after being written.
// ----------------------------------------------------------------------------
`default_nettype none
module hull_moving_average #(
   parameter int MAX_PERIOD = hma_pkg::MAX_PERIOD_DEF,
   parameter int DIFF_DEPTH = hma_pkg::DIFF_DEPTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [hma_pkg::PRICE_W-1:0]   req_close_price,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic signed [hma_pkg::HMA_W-1:0]   rsp_hma_value,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [hma_pkg::PERIOD_W-1:0]  csr_data
);

   localparam int  AW     = $clog2(MAX_PERIOD);
   localparam int  DW     = $clog2(DIFF_DEPTH);
   localparam int  PW     = $clog2(MAX_PERIOD + 1);
   localparam int  RW     = $clog2(DIFF_DEPTH + 1);
   localparam int  LW     = (PW > RW) ? PW : RW;
   localparam int  CW     = (PW > hma_pkg::PERIOD_W) ? PW : hma_pkg::PERIOD_W;
   localparam int  SW     = PW + 2;
   localparam longint WS_P = longint'(MAX_PERIOD) * (MAX_PERIOD + 1) / 2;
   localparam longint WS_D = longint'(DIFF_DEPTH) * (DIFF_DEPTH + 1) / 2;
   localparam int  WS_W   = $clog2(((WS_P > WS_D) ? WS_P : WS_D) + 1);
   localparam int  DATA_W = 36;
   localparam int  PROD_W = DATA_W + LW + 1;
   localparam int  ACC_W  = DATA_W + WS_W;

   hma_pkg::state_type state_ff, state_in;
   hma_pkg::phase_type phase_ff, phase_in;

   logic [hma_pkg::PERIOD_W-1:0] period_ff, period_in;
   logic [AW-1:0]     pslot_ff, pslot_in, paddr_ff, paddr_in;
   logic [DW-1:0]     dslot_ff, dslot_in, daddr_ff, daddr_in;
   logic [PW-1:0]     count_ff, count_in, n_ff, n_in;
   logic [SW-1:0]     s_ff, s_in, sq_ff, sq_in;
   logic [LW-1:0]     root_ff, root_in;
   logic [LW-1:0]     remain_ff, remain_in, w_ff, w_in, pipe_w_ff, pipe_w_in;
   logic              pipe_v_ff, pipe_v_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic [WS_W-1:0]   wsum_ff, wsum_in;
   logic              neg_ff, neg_in;
   logic [hma_pkg::PRICE_W-1:0] wn_ff, wn_in;
   logic [hma_pkg::HMA_W-1:0]   res_ff, res_in, rsp_data_ff, rsp_data_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic              accept, out_free;
   logic [CW-1:0]     period_ext;
   logic [PW-1:0]     n_clamp, n_next;
   logic [SW-1:0]     sq_next, root_raw;
   logic [LW-1:0]     count_l, len_full, len_half, len_diff;
   logic [AW-1:0]     pslot_next, pslot_prev;
   logic [DW-1:0]     dslot_next;
   logic [LW-1:0]     n_l, half_l;

   logic [hma_pkg::PRICE_W-1:0] price_rdata;
   logic [hma_pkg::DIFF_W-1:0]  diff_rdata, diff_value;
   logic              diff_wr;
   logic signed [DATA_W-1:0] mul_data;
   logic signed [LW:0]       mul_w;
   logic signed [PROD_W-1:0] prod;
   logic [ACC_W-1:0]  acc_mag, quotient;
   logic [hma_pkg::HMA_W-1:0] q_signed;
   logic              div_start;
   hma_pkg::div_ctl_type div_status;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != hma_pkg::ST_IDLE);
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // period clamped into [2, MAX_PERIOD]
   assign period_ext = CW'(period_ff);
   always_comb begin
      if (period_ext < CW'(2)) begin
         n_clamp = PW'(2);
      end else if (period_ext > CW'(MAX_PERIOD)) begin
         n_clamp = PW'(MAX_PERIOD);
      end else begin
         n_clamp = PW'(period_ext);
      end
   end

   assign pslot_next = (pslot_ff == AW'(MAX_PERIOD - 1)) ? '0 : pslot_ff + 1'b1;
   assign pslot_prev = (pslot_ff == '0) ? AW'(MAX_PERIOD - 1) : pslot_ff - 1'b1;
   assign dslot_next = (dslot_ff == DW'(DIFF_DEPTH - 1)) ? '0 : dslot_ff + 1'b1;
   assign n_next     = (count_ff < PW'(MAX_PERIOD)) ? count_ff + 1'b1 : count_ff;

   assign sq_next  = sq_ff + {s_ff[SW-2:0], 1'b0} + 1'b1;
   assign root_raw = ((SW'(n_ff) - sq_ff) > s_ff) ? s_ff + 1'b1 : s_ff;

   assign count_l  = LW'(count_ff);
   assign n_l      = LW'(n_ff);
   assign half_l   = LW'(n_ff >> 1);
   assign len_full = (n_l < count_l) ? n_l : count_l;
   assign len_half = (half_l < count_l) ? half_l : count_l;
   assign len_diff = (root_ff < count_l) ? root_ff : count_l;

   assign mul_data = (phase_ff == hma_pkg::PH_DIFF)
                     ? DATA_W'({diff_rdata[hma_pkg::DIFF_W-1], diff_rdata})
                     : DATA_W'({4'b0000, price_rdata});
   assign mul_w    = {1'b0, pipe_w_ff};
   assign prod     = PROD_W'(mul_data * mul_w);
   assign acc_mag  = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);
   assign q_signed = neg_ff ? hma_pkg::HMA_W'(-quotient) : hma_pkg::HMA_W'(quotient);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         hma_pkg::ST_IDLE: begin
            if (accept) state_in = hma_pkg::ST_ROOT;
         end
         hma_pkg::ST_ROOT: begin
            if (sq_next > SW'(n_ff)) state_in = hma_pkg::ST_WALK;
         end
         hma_pkg::ST_WALK: begin
            if (remain_ff == '0 && !pipe_v_ff) state_in = hma_pkg::ST_DIVIDE;
         end
         hma_pkg::ST_DIVIDE: begin
            if (div_status.done) begin
               state_in = (phase_ff == hma_pkg::PH_DIFF) ? hma_pkg::ST_DONE
                                                         : hma_pkg::ST_WALK;
            end
         end
         hma_pkg::ST_DONE: begin
            if (out_free) state_in = hma_pkg::ST_IDLE;
         end
         default: state_in = hma_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      period_in   = period_ff;
      phase_in    = phase_ff;
      pslot_in    = pslot_ff;
      dslot_in    = dslot_ff;
      paddr_in    = paddr_ff;
      daddr_in    = daddr_ff;
      count_in    = count_ff;
      n_in        = n_ff;
      s_in        = s_ff;
      sq_in       = sq_ff;
      root_in     = root_ff;
      remain_in   = remain_ff;
      w_in        = w_ff;
      pipe_v_in   = 1'b0;
      pipe_w_in   = pipe_w_ff;
      acc_in      = acc_ff;
      wsum_in     = wsum_ff;
      neg_in      = neg_ff;
      wn_in       = wn_ff;
      res_in      = res_ff;
      rsp_data_in = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      div_start   = 1'b0;
      diff_wr     = 1'b0;
      if (csr_valid && csr_ready) period_in = csr_data;
      case (state_ff)
         hma_pkg::ST_IDLE: begin
            if (accept) begin
               pslot_in = pslot_next;
               count_in = n_next;
               n_in     = n_clamp;
               s_in     = '0;
               sq_in    = '0;
            end
         end
         hma_pkg::ST_ROOT: begin
            if (sq_next <= SW'(n_ff)) begin
               s_in  = s_ff + 1'b1;
               sq_in = sq_next;
            end else begin
               root_in   = (root_raw > SW'(DIFF_DEPTH)) ? LW'(DIFF_DEPTH) : LW'(root_raw);
               phase_in  = hma_pkg::PH_FULL;
               remain_in = len_full;
               w_in      = len_full;
               paddr_in  = pslot_prev;
               acc_in    = '0;
               wsum_in   = '0;
            end
         end
         hma_pkg::ST_WALK: begin
            if (remain_ff != '0) begin
               pipe_v_in = 1'b1;
               pipe_w_in = w_ff;
               w_in      = w_ff - 1'b1;
               remain_in = remain_ff - 1'b1;
               paddr_in  = (paddr_ff == '0) ? AW'(MAX_PERIOD - 1) : paddr_ff - 1'b1;
               daddr_in  = (daddr_ff == '0) ? DW'(DIFF_DEPTH - 1) : daddr_ff - 1'b1;
            end
            if (pipe_v_ff) begin
               acc_in  = acc_ff + {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
               wsum_in = wsum_ff + WS_W'(pipe_w_ff);
            end
            if (remain_ff == '0 && !pipe_v_ff) begin
               div_start = 1'b1;
               neg_in    = acc_ff[ACC_W-1];
            end
         end
         hma_pkg::ST_DIVIDE: begin
            if (div_status.done) begin
               acc_in  = '0;
               wsum_in = '0;
               case (phase_ff)
                  hma_pkg::PH_FULL: begin
                     wn_in     = quotient[hma_pkg::PRICE_W-1:0];
                     phase_in  = hma_pkg::PH_HALF;
                     remain_in = len_half;
                     w_in      = len_half;
                     paddr_in  = pslot_prev;
                  end
                  hma_pkg::PH_HALF: begin
                     diff_wr   = 1'b1;
                     dslot_in  = dslot_next;
                     phase_in  = hma_pkg::PH_DIFF;
                     remain_in = len_diff;
                     w_in      = len_diff;
                     daddr_in  = dslot_ff;
                  end
                  default: begin
                     res_in = q_signed;
                  end
               endcase
            end
         end
         hma_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_data_in  = res_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // the difference is formed from the divider output (half average)
   // and the stored full average
   assign diff_value = hma_pkg::DIFF_W'({1'b0, quotient[hma_pkg::PRICE_W-1:0], 1'b0}) -
                       hma_pkg::DIFF_W'({3'b000, wn_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hma_pkg::ST_IDLE;
         phase_ff     <= hma_pkg::PH_FULL;
         period_ff    <= hma_pkg::PERIOD_RESET;
         pslot_ff     <= '0;
         dslot_ff     <= '0;
         count_ff     <= '0;
         remain_ff    <= '0;
         pipe_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         period_ff    <= period_in;
         pslot_ff     <= pslot_in;
         dslot_ff     <= dslot_in;
         count_ff     <= count_in;
         remain_ff    <= remain_in;
         pipe_v_ff    <= pipe_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      paddr_ff    <= paddr_in;
      daddr_ff    <= daddr_in;
      n_ff        <= n_in;
      s_ff        <= s_in;
      sq_ff       <= sq_in;
      root_ff     <= root_in;
      w_ff        <= w_in;
      pipe_w_ff   <= pipe_w_in;
      acc_ff      <= acc_in;
      wsum_ff     <= wsum_in;
      neg_ff      <= neg_in;
      wn_ff       <= wn_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   hma_ram #(
      .WIDTH (hma_pkg::PRICE_W),
      .DEPTH (MAX_PERIOD)
   ) u_price_ring (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (pslot_ff),
      .wr_data (req_close_price),
      .rd_addr (paddr_ff),
      .rd_data (price_rdata)
   );

   hma_ram #(
      .WIDTH (hma_pkg::DIFF_W),
      .DEPTH (DIFF_DEPTH)
   ) u_diff_ring (
      .clock   (clock),
      .wr_en   (diff_wr),
      .wr_addr (dslot_ff),
      .wr_data (diff_value),
      .rd_addr (daddr_ff),
      .rd_data (diff_rdata)
   );

   hma_div #(
      .NUM_W (ACC_W),
      .DEN_W (WS_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (acc_mag),
      .divisor  (wsum_ff),
      .status   (div_status),
      .quotient (quotient)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_hma_value = rsp_data_ff;

`ifndef ASSERT_OFF
   a_accept_busy : assert property (@(posedge clock) disable iff (reset)
      accept |=> req_stall)
      else $error("request accepted but block not busy afterward");

   a_div_done_state : assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> state_ff == hma_pkg::ST_DIVIDE)
      else $error("divider finished outside divide state");

   a_count_range : assert property (@(posedge clock) disable iff (reset)
      count_ff <= PW'(MAX_PERIOD))
      else $error("sample count beyond max period");

   a_load_free : assert property (@(posedge clock) disable iff (reset)
      (state_ff == hma_pkg::ST_DONE && !out_free) |=> $stable(rsp_data_ff))
      else $error("result overwritten while output register held");
`endif

endmodule
`default_nettype wire
